FILE: rtl/psynth_pkg.sv
package psynth_pkg;

  localparam int unsigned PERIOD_W = 12;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned NOISE_W  = 13;

  localparam logic [PERIOD_W-1:0] MIN_PERIOD = 12'd2;
  localparam logic [SAMPLE_W-1:0] SEED_RESET = 16'h0001;
  localparam logic [SAMPLE_W-1:0] LFSR_TAPS  = 16'hB400;

  localparam logic REQ_NOTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef struct packed {
    logic                req_type;
    logic [PERIOD_W-1:0] period;
  } req_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       excitation;
  } rsp_t;

  typedef struct packed {
    logic                valid;
    logic                excite;
    logic [SAMPLE_W-1:0] noise;
  } stage_t;

  function automatic logic [SAMPLE_W-1:0] floor_avg(logic [SAMPLE_W-1:0] a,
                                                   logic [SAMPLE_W-1:0] b);
    logic [SAMPLE_W:0] sum;
    sum = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
    return sum[SAMPLE_W:1];
  endfunction

endpackage

FILE: rtl/psynth_ram.sv
module psynth_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem[raddr_a_i];
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

FILE: rtl/psynth_ctrl.sv
module psynth_ctrl #(
  parameter int unsigned DELAY_DEPTH = 4096,
  localparam int unsigned AW         = $clog2(DELAY_DEPTH)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [psynth_pkg::SAMPLE_W-1:0]      cfg_wdata_i,
  input  logic                                 in_valid_i,
  input  psynth_pkg::req_t                     in_data_i,
  output logic                                 in_stall_o,
  input  logic                                 s1_adv_i,
  output logic                                 rd_en_o,
  output logic [AW-1:0]                        rd_addr_a_o,
  output logic [AW-1:0]                        rd_addr_b_o,
  output psynth_pkg::stage_t                   s1_o,
  output logic [AW-1:0]                        s1_waddr_o
);

  import psynth_pkg::*;

  localparam int unsigned CW     = ((AW > PERIOD_W) ? AW : PERIOD_W) + 1;
  localparam int unsigned PMAX_I = (DELAY_DEPTH - 1 > 4095) ? 4095 : DELAY_DEPTH - 1;
  localparam logic [PERIOD_W-1:0] PMAX = PERIOD_W'(PMAX_I);

  logic [AW-1:0]       wp_q, wp_d;
  logic [PERIOD_W-1:0] period_q, period_d;
  logic [NOISE_W-1:0]  noise_q, noise_d;
  logic [SAMPLE_W-1:0] lfsr_q, lfsr_d;
  logic                s1_valid_q, s1_valid_d;
  logic                s1_excite_q;
  logic [SAMPLE_W-1:0] s1_noise_q;
  logic [AW-1:0]       s1_waddr_q;

  logic                accept, tick, note;
  logic [PERIOD_W-1:0] p_clamp;
  logic [CW-1:0]       wp_x, p_x, i1_x;
  logic [AW-1:0]       i1;

  assign in_stall_o = s1_valid_q && !s1_adv_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign tick       = accept && (in_data_i.req_type == REQ_TICK);
  assign note       = accept && (in_data_i.req_type == REQ_NOTE);

  always_comb begin
    if (in_data_i.period < MIN_PERIOD) begin
      p_clamp = MIN_PERIOD;
    end else if (in_data_i.period > PMAX) begin
      p_clamp = PMAX;
    end else begin
      p_clamp = in_data_i.period;
    end
  end

  assign wp_x = CW'(wp_q);
  assign p_x  = CW'(period_q);
  assign i1_x = (wp_x >= p_x) ? wp_x - p_x : wp_x + CW'(DELAY_DEPTH) - p_x;
  assign i1   = i1_x[AW-1:0];

  assign rd_en_o     = tick;
  assign rd_addr_a_o = i1;
  assign rd_addr_b_o = (i1 == '0) ? AW'(DELAY_DEPTH - 1) : i1 - AW'(1);

  always_comb begin
    wp_d       = wp_q;
    period_d   = period_q;
    noise_d    = noise_q;
    lfsr_d     = lfsr_q;
    s1_valid_d = s1_valid_q;
    if (s1_adv_i) begin
      s1_valid_d = 1'b0;
    end
    if (note) begin
      period_d = p_clamp;
      noise_d  = NOISE_W'(p_clamp) + NOISE_W'(1);
    end
    if (tick) begin
      s1_valid_d = 1'b1;
      wp_d       = (wp_q == AW'(DELAY_DEPTH - 1)) ? '0 : wp_q + AW'(1);
      if (noise_q != '0) begin
        noise_d = noise_q - NOISE_W'(1);
        lfsr_d  = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_TAPS) : (lfsr_q >> 1);
      end
    end
    if (cfg_we_i) begin
      lfsr_d = (cfg_wdata_i == '0) ? SEED_RESET : cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= '0;
      period_q   <= MIN_PERIOD;
      noise_q    <= '0;
      lfsr_q     <= SEED_RESET;
      s1_valid_q <= 1'b0;
    end else begin
      wp_q       <= wp_d;
      period_q   <= period_d;
      noise_q    <= noise_d;
      lfsr_q     <= lfsr_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick) begin
      s1_excite_q <= (noise_q != '0);
      s1_noise_q  <= lfsr_q;
      s1_waddr_q  <= wp_q;
    end
  end

  assign s1_o.valid  = s1_valid_q;
  assign s1_o.excite = s1_excite_q;
  assign s1_o.noise  = s1_noise_q;
  assign s1_waddr_o  = s1_waddr_q;

endmodule

FILE: rtl/plucked_string_synth.sv
// Pipeline: a tick beat's sample is read into the stage-1 registers at accept, then
// moves to the output register when the output is not held. Note-start beats give no result.
// Throughput: one beat per cycle while the output is not stalled, set by the single
// delay-line write port (read at accept, write-back when stage 1 advances).
// Reset: control state clears, the noise generator loads seed 1, the period is 2;
// the delay line is not cleared.
module plucked_string_synth #(
  parameter int unsigned DELAY_DEPTH = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [psynth_pkg::SAMPLE_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  input  psynth_pkg::req_t                in_data_i,
  output logic                            in_stall_o,
  output logic                            out_valid_o,
  output psynth_pkg::rsp_t                out_data_o,
  input  logic                            out_stall_i
);

  import psynth_pkg::*;

  localparam int unsigned AW = $clog2(DELAY_DEPTH);

  logic                rd_en;
  logic [AW-1:0]       rd_addr_a, rd_addr_b;
  logic [SAMPLE_W-1:0] rd_data_a, rd_data_b;
  stage_t              s1;
  logic [AW-1:0]       s1_waddr;
  logic                s1_adv;
  logic [SAMPLE_W-1:0] sample;
  logic                out_valid_q, out_valid_d;
  rsp_t                out_data_q;

  psynth_ctrl #(
    .DELAY_DEPTH(DELAY_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .s1_adv_i    (s1_adv),
    .rd_en_o     (rd_en),
    .rd_addr_a_o (rd_addr_a),
    .rd_addr_b_o (rd_addr_b),
    .s1_o        (s1),
    .s1_waddr_o  (s1_waddr)
  );

  psynth_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(DELAY_DEPTH)
  ) u_delay (
    .clk_i     (clk_i),
    .we_i      (s1_adv),
    .waddr_i   (s1_waddr),
    .wdata_i   (sample),
    .re_i      (rd_en),
    .raddr_a_i (rd_addr_a),
    .raddr_b_i (rd_addr_b),
    .rdata_a_o (rd_data_a),
    .rdata_b_o (rd_data_b)
  );

  assign s1_adv = s1.valid && (!out_valid_q || !out_stall_i);
  assign sample = s1.excite ? s1.noise : floor_avg(rd_data_a, rd_data_b);

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q.sample     <= sample;
      out_data_q.excitation <= s1.excite;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && rd_en) |-> (s1_waddr != rd_addr_a && s1_waddr != rd_addr_b))
    else $error("delay line write collides with a read");

  a_tick_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |=> s1.valid)
    else $error("accepted tick lost before write-back");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (!s1.valid || s1_adv))
    else $error("tick accepted over a blocked stage");

  a_adv_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !s1_adv)
    else $error("output overwritten while held");

endmodule

FILE: tb/string_sample_checker.sv
`timescale 1ns / 100ps
module string_sample_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [psynth_pkg::SAMPLE_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  input  psynth_pkg::req_t                in_data_i,
  input  logic                            in_stall_i,
  input  logic                            out_valid_i,
  input  psynth_pkg::rsp_t                out_data_i,
  input  logic                            out_stall_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  import psynth_pkg::*;

  localparam int unsigned LINE_DEPTH = 4096;

  logic [SAMPLE_W-1:0] string_line [LINE_DEPTH];
  logic [PERIOD_W-1:0] wr_pos;
  logic [PERIOD_W-1:0] cur_period;
  logic [NOISE_W-1:0]  noise_left;
  logic [SAMPLE_W-1:0] lfsr_q;
  rsp_t                samples_due [$];

  task automatic predict_sample(input req_t beat);
    logic [PERIOD_W-1:0] p;
    logic [PERIOD_W-1:0] tap_near;
    logic [PERIOD_W-1:0] tap_far;
    logic [SAMPLE_W-1:0] a;
    logic [SAMPLE_W-1:0] b;
    logic [SAMPLE_W:0]   sum;
    logic [SAMPLE_W-1:0] s;
    logic                ex;
    rsp_t                r;
    if (beat.req_type == REQ_NOTE) begin
      // 12-bit period can never exceed depth - 1, only the low clamp applies
      p = (beat.period < MIN_PERIOD) ? MIN_PERIOD : beat.period;
      cur_period = p;
      noise_left = {1'b0, p} + 1'b1;
    end else begin
      if (noise_left != '0) begin
        s = lfsr_q;
        lfsr_q = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_TAPS) : (lfsr_q >> 1);
        noise_left = noise_left - 1'b1;
        ex = 1'b1;
      end else begin
        tap_near = wr_pos - cur_period;
        tap_far = tap_near - 1'b1;
        a = string_line[tap_near];
        b = string_line[tap_far];
        sum = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
        s = sum[SAMPLE_W:1];
        ex = 1'b0;
      end
      string_line[wr_pos] = s;
      wr_pos = wr_pos + 1'b1;
      r.sample = s;
      r.excitation = ex;
      samples_due.push_back(r);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      wr_pos = '0;
      cur_period = MIN_PERIOD;
      noise_left = '0;
      lfsr_q = SEED_RESET;
      samples_due.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (samples_due.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) begin
            $display("unexpected output beat: sample %0d excitation %0b",
                     out_data_i.sample, out_data_i.excitation);
          end
        end else begin
          want = samples_due.pop_front();
          if (out_data_i.sample !== want.sample ||
              out_data_i.excitation !== want.excitation) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("mismatch: sample exp %0d got %0d, excitation exp %0b got %0b",
                       want.sample, out_data_i.sample,
                       want.excitation, out_data_i.excitation);
            end
          end
        end
      end
      if (cfg_we_i) begin
        lfsr_q = (cfg_wdata_i == '0) ? SEED_RESET : cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_i) begin
        predict_sample(in_data_i);
      end
      pending_o = samples_due.size();
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
module tb;
  import psynth_pkg::*;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [SAMPLE_W-1:0] cfg_wdata;
  logic                in_valid;
  req_t                in_data;
  logic                in_stall;
  logic                out_valid;
  rsp_t                out_data;
  logic                out_stall;

  int fail_count;
  int pending;
  int beats_sent;
  int in_idle_pct;
  int out_idle_pct;

  plucked_string_synth #(
    .DELAY_DEPTH(4096)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_data_i  (in_data),
    .in_stall_o (in_stall),
    .out_valid_o(out_valid),
    .out_data_o (out_data),
    .out_stall_i(out_stall)
  );

  string_sample_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_data_i   (in_data),
    .in_stall_i  (in_stall),
    .out_valid_i (out_valid),
    .out_data_i  (out_data),
    .out_stall_i (out_stall),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall <= ($urandom_range(0, 99) < out_idle_pct);
  end

  task automatic send_beat(input req_t beat);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic play_note(input int unsigned p, input int unsigned n_ticks);
    req_t beat;
    beat.req_type = REQ_NOTE;
    beat.period = p[PERIOD_W-1:0];
    send_beat(beat);
    repeat (n_ticks) begin
      beat.req_type = REQ_TICK;
      beat.period = PERIOD_W'($urandom_range(0, 4095));
      send_beat(beat);
    end
  endtask

  // lower valid, wait for every sample, then let a note beat in flight retire
  task automatic settle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic load_seed(input logic [SAMPLE_W-1:0] seed);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= seed;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int budget);
    int target;
    int roll;
    int unsigned p;
    int unsigned eff;
    int unsigned n;
    target = beats_sent + budget;
    while (beats_sent < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
        roll = $urandom_range(0, 99);
        if (roll < 85) p = $urandom_range(2, 40);
        else if (roll < 95) p = $urandom_range(41, 300);
        else if (roll < 98) p = $urandom_range(0, 1);
        else p = $urandom_range(3000, 4095);
        eff = (p < 2) ? 2 : p;
        if (eff <= 40) n = $urandom_range(0, 3 * eff + 8);
        else if (eff <= 300) n = $urandom_range(eff, eff + 60);
        else n = $urandom_range(0, 60);
        play_note(p, n);
      end else if (roll < 88) begin
        repeat ($urandom_range(1, 12)) begin
          send_beat('{req_type: REQ_TICK, period: PERIOD_W'($urandom_range(0, 4095))});
        end
      end else if (roll < 95) begin
        send_beat('{req_type: REQ_NOTE, period: PERIOD_W'($urandom_range(0, 4095))});
        play_note($urandom_range(0, 24), $urandom_range(0, 20));
      end else begin
        settle();
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_data = '0;
    beats_sent = 0;
    in_idle_pct = 0;
    out_idle_pct = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // zero seed, clamped periods, longest period, restart mid-noise
    load_seed(16'h0000);
    play_note(0, 6);
    play_note(1, 5);
    play_note(2, 4);
    play_note(4095, 3);
    play_note(3, 6);
    settle();

    load_seed(16'hFFFF);
    in_idle_pct = 7;
    out_idle_pct = 52;
    run_phase(620);
    settle();

    load_seed(SAMPLE_W'($urandom_range(1, 65535)));
    in_idle_pct = 52;
    out_idle_pct = 7;
    run_phase(620);
    settle();

    load_seed(16'h0001);
    in_idle_pct = 0;
    out_idle_pct = 0;
    run_phase(620);
    settle();

    repeat (8) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

endmodule
